/* rtl/core/aaq_pkg.sv */
// ----------------------------------------------------------------------------
// aaq_pkg
// Shared types and constants for the ancestor age query block.
// ----------------------------------------------------------------------------
package aaq_pkg;

  localparam int NODE_W = 10;
  localparam int NODES  = 2 ** NODE_W;
  localparam int AGE_W  = 32;
  localparam int TAG_W  = 16;

  // Request codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Answer status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent_node;
    logic              is_root;
    logic [AGE_W-1:0]  node_age;
    logic [AGE_W-1:0]  climb_limit;
    logic [TAG_W-1:0]  query_tag;
  } in_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  answer_tag;
    logic [NODE_W-1:0] answer_node;
    logic              status;
  } out_rsp_t;

  // One row of the node table: shortcut, parent link and age
  typedef struct packed {
    logic              sc_valid;
    logic [NODE_W-1:0] sc;
    logic              root;
    logic [NODE_W-1:0] parent;
    logic [AGE_W-1:0]  age;
  } node_entry_t;

endpackage

/* rtl/core/ancestor_age_query_top.sv */
// ----------------------------------------------------------------------------
// ancestor_age_query_top
// Ancestor lookup by age limit over a loaded tree, with path compression.
// ----------------------------------------------------------------------------
// A load request writes one node's parent (or root mark) and age, drops that
// node's shortcut and resets the query order tracker; it gives no result. A
// query request climbs from its start node, taking the shortcut where one
// is valid and the parent otherwise, while the next node's age is within
// the limit, and answers with the node where the climb stops.
// Every node visited on the way (other than the answer) then gets a shortcut
// to the answer. A query whose limit is below that of the last accepted query
// is answered with status 1 and node 0 and changes nothing. An accepted query
// runs the climb with one read of the node table per step, then a shortcut
// write-back pass over the visited nodes through the one write port, then the
// hand-off to the output register. Path compression keeps the climb short
// over a run of queries. After reset the block runs a clearing pass over all
// NODES (1024) entries of the node table, with in_ready low.
// The next request is taken while a result still waits in the output
// register; a finished walk holds until that register is free.
// ----------------------------------------------------------------------------
module ancestor_age_query_top
  import aaq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  // Visited-node stack holds up to NODES + 1 entries (climb is capped)
  localparam int VIS_DEPTH = NODES + 1;
  localparam int VIS_AW    = $clog2(VIS_DEPTH);
  localparam int CNT_W     = $clog2(VIS_DEPTH + 1);

  // Control states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FIX   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Node table and visited stack
  node_entry_t       node_mem [NODES];
  logic [NODE_W-1:0] vis_mem  [VIS_DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [NODE_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [AGE_W-1:0]  last_limit_r, last_limit_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] cand_r, cand_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  fix_idx_r, fix_idx_nxt;
  logic              fix_vld_r, fix_vld_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic              status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_r, out_nxt;

  // Memory port signals
  node_entry_t       rd_data_r;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_full;
  logic              wr_sc;
  logic [NODE_W-1:0] wr_addr;
  node_entry_t       wr_data;
  logic              vis_we;
  logic [VIS_AW-1:0] vis_wa;
  logic [NODE_W-1:0] vis_wd;
  logic              vis_re;
  logic [NODE_W-1:0] vis_rd_r;

  // Next hop out of the entry just read
  logic              hop_ok;
  logic [NODE_W-1:0] hop_idx;
  logic              in_fire;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign hop_ok  = rd_data_r.sc_valid || !rd_data_r.root;
  assign hop_idx = rd_data_r.sc_valid ? rd_data_r.sc : rd_data_r.parent;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    last_limit_nxt = last_limit_r;
    cur_nxt        = cur_r;
    cand_nxt       = cand_r;
    cnt_nxt        = cnt_r;
    fix_idx_nxt    = fix_idx_r;
    fix_vld_nxt    = 1'b0;
    tag_nxt        = tag_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    rd_en   = 1'b0;
    rd_addr = in_data.node;
    wr_full = 1'b0;
    wr_sc   = 1'b0;
    wr_addr = clr_idx_r;
    wr_data = '0;
    vis_we  = 1'b0;
    vis_wa  = '0;
    vis_wd  = in_data.node;
    vis_re  = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // Sweep the table once: every shortcut starts invalid
        wr_full     = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + NODE_W'(1);
        if (clr_idx_r == NODE_W'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          if (in_data.action == ACT_LOAD) begin
            wr_full        = 1'b1;
            wr_addr        = in_data.node;
            wr_data.root   = in_data.is_root;
            wr_data.parent = in_data.is_root ? '0 : in_data.parent_node;
            wr_data.age    = in_data.node_age;
            last_limit_nxt = '0;
          end else begin
            tag_nxt = in_data.query_tag;
            if (in_data.climb_limit < last_limit_r) begin
              // Out of order: answer at once, walk nothing
              status_nxt = ST_REJECT;
              cur_nxt    = '0;
              state_nxt  = S_DONE;
            end else begin
              status_nxt     = ST_OK;
              last_limit_nxt = in_data.climb_limit;
              rd_en          = 1'b1;
              rd_addr        = in_data.node;
              cur_nxt        = in_data.node;
              vis_we         = 1'b1;
              vis_wa         = '0;
              vis_wd         = in_data.node;
              cnt_nxt        = CNT_W'(1);
              fix_idx_nxt    = '0;
              state_nxt      = S_FIRST;
            end
          end
        end
      end

      S_FIRST: begin
        // Start node's entry is back; its age is not checked
        if (!hop_ok) begin
          state_nxt = S_FIX;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = hop_idx;
          cand_nxt  = hop_idx;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        // Entry of the candidate is back: check age, then issue next hop
        if (rd_data_r.age > last_limit_r) begin
          state_nxt = S_FIX;
        end else begin
          cur_nxt = cand_r;
          vis_we  = 1'b1;
          vis_wa  = cnt_r[VIS_AW-1:0];
          vis_wd  = cand_r;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(VIS_DEPTH - 1) || !hop_ok) begin
            state_nxt = S_FIX;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = hop_idx;
            cand_nxt = hop_idx;
          end
        end
      end

      S_FIX: begin
        // Replay the stack and point every visited node at the answer
        if (fix_idx_r != cnt_r) begin
          vis_re      = 1'b1;
          fix_idx_nxt = fix_idx_r + CNT_W'(1);
          fix_vld_nxt = 1'b1;
        end
        if (fix_vld_r && (vis_rd_r != cur_r)) begin
          wr_sc   = 1'b1;
          wr_addr = vis_rd_r;
        end
        wr_data.sc_valid = 1'b1;
        wr_data.sc       = cur_r;
        if (fix_idx_r == cnt_r && !fix_vld_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register frees up
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.answer_tag  = tag_r;
          out_nxt.answer_node = cur_r;
          out_nxt.status      = status_r;
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      last_limit_r <= '0;
      fix_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      last_limit_r <= last_limit_nxt;
      fix_vld_r    <= fix_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cand_r    <= cand_nxt;
    cnt_r     <= cnt_nxt;
    fix_idx_r <= fix_idx_nxt;
    tag_r     <= tag_nxt;
    status_r  <= status_nxt;
    out_r     <= out_nxt;
  end

  // Node table: one read port, one write port with a shortcut-only lane.
  // Reads happen only in the climb and writes only outside it, so no
  // forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_full) begin
      node_mem[wr_addr] <= wr_data;
    end else if (wr_sc) begin
      node_mem[wr_addr].sc_valid <= wr_data.sc_valid;
      node_mem[wr_addr].sc       <= wr_data.sc;
    end
    if (rd_en) begin
      rd_data_r <= node_mem[rd_addr];
    end
  end

  // Visited stack: pushed during the climb, replayed during write-back
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (vis_re) begin
      vis_rd_r <= vis_mem[fix_idx_r[VIS_AW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VIS_DEPTH) || state_r == S_IDLE || state_r == S_CLEAR)
    else $error("visited count beyond stack depth");

  a_no_self_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
    wr_sc |-> (wr_addr != cur_r))
    else $error("shortcut written on the answer node");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRST || state_r == S_WALK) |-> !(wr_full || wr_sc))
    else $error("node table written during the climb");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the hand-off state");

  a_reject_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_REJECT) |-> (out_r.answer_node == '0))
    else $error("rejected query carries a node");
`endif

endmodule

/* test/aaq_tracker_pkg.sv */
// ----------------------------------------------------------------------------
// aaq_tracker_pkg
// Tracks the node tables and checks the answers of the ancestor age query block.
// ----------------------------------------------------------------------------
package aaq_tracker_pkg;

  import aaq_pkg::*;

  class ancestor_tracker;

    // Own copy of the node table: parent link, root mark, age and shortcut
    logic [NODE_W-1:0] up_link  [NODES];
    bit                is_top   [NODES];
    logic [AGE_W-1:0]  age_of   [NODES];
    bit                jump_ok  [NODES];
    logic [NODE_W-1:0] jump_to  [NODES];
    logic [AGE_W-1:0]  floor_limit;

    out_rsp_t awaited_answers[$];

    int loads_seen;
    int queries_seen;
    int rejects_seen;
    int deepest;
    int answers_seen;
    int mismatches;
    int strays;
    int reported;

    function new();
      for (int i = 0; i < NODES; i++) begin
        up_link[i] = '0;
        is_top[i]  = 1'b0;
        age_of[i]  = '0;
        jump_ok[i] = 1'b0;
        jump_to[i] = '0;
      end
      floor_limit = '0;
    endfunction

    // Apply one accepted request and, for a query, queue the answer it must produce.
    function void take_request(in_req_t r);
      logic [NODE_W-1:0] at;
      logic [NODE_W-1:0] step_to;
      logic [NODE_W-1:0] trail[$];
      out_rsp_t          want;
      if (r.action == ACT_LOAD) begin
        up_link[r.node] = r.parent_node;
        is_top[r.node]  = r.is_root;
        age_of[r.node]  = r.node_age;
        jump_ok[r.node] = 1'b0;
        floor_limit     = '0;
        loads_seen++;
        return;
      end
      queries_seen++;
      want.answer_tag = r.query_tag;
      if (r.climb_limit < floor_limit) begin
        want.answer_node = '0;
        want.status      = ST_REJECT;
        rejects_seen++;
      end else begin
        floor_limit = r.climb_limit;
        at = r.node;
        trail.insert(trail.size(), at);
        for (int s = 0; s < NODES; s++) begin
          if (jump_ok[at]) begin
            step_to = jump_to[at];
          end else if (is_top[at]) begin
            break;
          end else begin
            step_to = up_link[at];
          end
          if (age_of[step_to] > r.climb_limit) break;
          at = step_to;
          trail.insert(trail.size(), at);
        end
        // compress: every node passed on the way now points at the answer
        foreach (trail[i]) begin
          if (trail[i] != at) begin
            jump_ok[trail[i]] = 1'b1;
            jump_to[trail[i]] = at;
          end
        end
        if (trail.size() - 1 > deepest) deepest = trail.size() - 1;
        want.answer_node = at;
        want.status      = ST_OK;
      end
      awaited_answers.insert(awaited_answers.size(), want);
    endfunction

    function void check_answer(out_rsp_t got);
      out_rsp_t want;
      if (awaited_answers.size() == 0) begin
        strays++;
        if (reported < 10) begin
          $display("unexpected answer: tag %h node %0d status %0d",
                   got.answer_tag, got.answer_node, got.status);
          reported++;
        end
        return;
      end
      want = awaited_answers.pop_front();
      answers_seen++;
      if (got.answer_tag !== want.answer_tag || got.answer_node !== want.answer_node ||
          got.status !== want.status) begin
        mismatches++;
        if (reported < 10) begin
          $display("answer mismatch: expected tag %h node %0d status %0d,",
                   want.answer_tag, want.answer_node, want.status);
          $display("                 got tag %h node %0d status %0d",
                   got.answer_tag, got.answer_node, got.status);
          reported++;
        end
      end
    endfunction

    function int awaited();
      return awaited_answers.size();
    endfunction

  endclass

endpackage

/* test/ancestor_age_query_top_test.sv */
// ----------------------------------------------------------------------------
// ancestor_age_query_top_test
// Self-checking bench for the ancestor age query block with path compression.
// ----------------------------------------------------------------------------
// Loads build a forest in the node table and queries climb it with rising age
// limits. A directed opening covers roots, field extremes, shortcut reuse,
// out-of-order limits and a cyclic parent chain; the random part then runs
// phases of loads followed by query batches with non-decreasing limits, mixed
// with out-of-order limits and stray loads. Every answer is checked against a
// tracked copy of the tables. Random load/query shaping keeps every parent
// link pointing at a lower, already loaded node, so no climb ever touches an
// unwritten entry and no cycle forms outside the directed check.
// ----------------------------------------------------------------------------
module ancestor_age_query_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import aaq_pkg::*;
  import aaq_tracker_pkg::*;

  localparam int ITEM_TARGET = 1350;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  ancestor_tracker tracker = new();

  // Generator view of the table: which nodes hold a parent and an age
  bit loaded [NODES];
  int loaded_nodes[$];

  int requests_sent;
  bit no_idle;          // both sides run without gaps while set
  int hold_off_cycles;  // one-shot long stall for the answer side

  ancestor_age_query_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The timeout below leaves ample margin over the slowest correct run: a
  // clearing pass, then about 1400 requests each climbing the whole table
  // behind random gaps and stalls, plus the answer-side hold-offs.
  initial begin
    #80_000_000;
    $display("[ancestor_age_query_top] ERROR");
    $finish;
  end

  // Uniform value in 0..bound, full 32-bit range included.
  function automatic logic [31:0] draw_upto(logic [31:0] bound);
    return (bound == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, bound);
  endfunction

  // Hold the request until the block takes it; the gap before it is random.
  task automatic push_request(input in_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = r;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_request(r);
    requests_sent++;
  endtask

  // Drop valid and wait for every queued answer to come back.
  task automatic drain_answers();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.awaited() != 0) @(posedge clk);
  endtask

  task automatic send_load(input int n, input logic [NODE_W-1:0] parent, input logic root,
                           input logic [AGE_W-1:0] age);
    in_req_t r;
    r.action      = ACT_LOAD;
    r.node        = NODE_W'(n);
    r.parent_node = parent;
    r.is_root     = root;
    r.node_age    = age;
    r.climb_limit = $urandom;   // ignored by a load
    r.query_tag   = TAG_W'($urandom);
    if (!loaded[n]) begin
      loaded[n] = 1'b1;
      loaded_nodes.insert(loaded_nodes.size(), n);
    end
    push_request(r);
  endtask

  task automatic send_query(input int n, input logic [AGE_W-1:0] limit,
                            input logic [TAG_W-1:0] tag);
    in_req_t r;
    r.action      = ACT_QUERY;
    r.node        = NODE_W'(n);
    r.parent_node = NODE_W'($urandom);   // ignored by a query
    r.is_root     = 1'($urandom);
    r.node_age    = $urandom;
    r.climb_limit = limit;
    r.query_tag   = tag;
    push_request(r);
  endtask

  // Load a random node. Its parent is a loaded node below it: half the time
  // the nearest one (builds long chains), else any; roots now and then.
  task automatic random_load(input logic [31:0] scale);
    int          n;
    int          nearest;
    int          parent;
    logic [31:0] age;
    n       = $urandom_range(0, NODES - 1);
    nearest = -1;
    for (int i = n - 1; i >= 0; i--) begin
      if (loaded[i]) begin
        nearest = i;
        break;
      end
    end
    parent = nearest;
    if (nearest >= 0 && $urandom_range(0, 1) == 0) begin
      repeat (8) begin
        int k;
        k = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        if (k < n) begin
          parent = k;
          break;
        end
      end
    end
    case ($urandom_range(0, 31))
      0:       age = '0;
      1:       age = 32'hFFFF_FFFF;
      default: age = draw_upto(scale);
    endcase
    if (parent < 0 || $urandom_range(0, 15) == 0) begin
      send_load(n, NODE_W'($urandom), 1'b1, age);
    end else begin
      send_load(n, NODE_W'(parent), 1'b0, age);
    end
  endtask

  // Answer side: random stall per answer, or the long hold-off when asked.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      tracker.check_answer(out_data);
    end
  end

  initial begin
    int            phase;
    int            nloads;
    int            nq;
    int            pick;
    int            a;
    int            b;
    logic [31:0]   scale;
    logic [31:0]   step;
    logic [31:0]   ceiling;
    logic [31:0]   limit;
    logic [32:0]   nxt;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: a short chain 1023 -> 2 -> 1 -> 0 with a root at 0.
    send_load(0, 10'h3FF, 1'b1, 32'h0);
    send_load(1, 10'd0, 1'b0, 32'd5);
    send_load(2, 10'd1, 1'b0, 32'd10);
    send_load(1023, 10'd2, 1'b0, 32'hFFFF_FFFF);
    send_query(1023, 32'h0, 16'h0000);           // first step already too old
    send_query(1023, 32'd10, 16'hFFFF);          // climb to the root, equal age
    send_query(2, 32'd4, 16'h1234);              // limit drops: reject
    send_query(1023, 32'd10, 16'h0001);          // follow the new shortcut
    send_query(0, 32'hFFFF_FFFF, 16'h0002);      // start at a root
    send_query(1, 32'h0, 16'h0003);              // below the top limit: reject
    send_load(3, 10'd2, 1'b0, 32'h0);            // a load resets the order
    send_query(3, 32'h0, 16'h0004);
    // Cyclic parent chain 1021 -> 1022 -> 1023 -> 1021: climb is capped.
    send_load(1021, 10'd1022, 1'b0, 32'd1);
    send_load(1022, 10'd1023, 1'b0, 32'd1);
    send_load(1023, 10'd1021, 1'b0, 32'd1);
    send_query(1021, 32'd1, 16'h0005);
    // Break the cycle so every parent link points downward again.
    send_load(1021, 10'd0, 1'b0, 32'd3);
    send_load(1022, 10'd1021, 1'b0, 32'd2);
    send_query(1023, 32'd3, 16'h0006);
    send_query(1022, 32'd2, 16'h0007);

    // Random phases: loads, then a batch of queries with rising limits.
    phase = 0;
    while (requests_sent < ITEM_TARGET) begin
      phase++;
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 3))
        0:       scale = 32'd15;
        1:       scale = 32'd1000;
        2:       scale = 32'd1_000_000;
        default: scale = 32'hFFFF_FFFF;
      endcase
      nloads = (loaded_nodes.size() < 96) ? $urandom_range(16, 40) : $urandom_range(1, 10);
      repeat (nloads) random_load(scale);

      // Pause the sender until the pipe is empty now and then.
      if (phase % 9 == 4) drain_answers();

      nq = $urandom_range(4, 30);
      // Stall the answer side for a long stretch while queries keep coming,
      // so the block fills up and backs up its input.
      if (phase % 11 == 3) begin
        hold_off_cycles = 400;
        nq = 40;
      end

      step    = scale / nq * 2;
      ceiling = '0;
      repeat (nq) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          random_load(scale);
          ceiling = '0;
        end else begin
          if (pick < 12 && ceiling != 0) begin
            limit = $urandom_range(0, ceiling - 1);
          end else if (pick < 15) begin
            limit = 32'hFFFF_FFFF;
          end else begin
            nxt   = {1'b0, ceiling} + draw_upto(step);
            limit = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
          end
          if (limit >= ceiling) ceiling = limit;
          // favor higher indices: they tend to sit deeper in the forest
          a = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
          b = loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
          send_query((a > b) ? a : b, limit, TAG_W'($urandom));
        end
      end
    end

    drain_answers();
    repeat (64) @(posedge clk);

    $display("Run covered %0d requests: %0d loads, %0d queries (%0d out of order),",
             requests_sent, tracker.loads_seen, tracker.queries_seen,
             tracker.rejects_seen);
    $display("deepest climb %0d steps; answers checked %0d, mismatched %0d, unexpected %0d.",
             tracker.deepest, tracker.answers_seen, tracker.mismatches, tracker.strays);
    if (tracker.mismatches == 0 && tracker.strays == 0 && tracker.awaited() == 0) begin
      $display("[ancestor_age_query_top] OK");
    end else begin
      $display("[ancestor_age_query_top] ERROR");
    end
    $finish;
  end

endmodule
